>>> design/keypad_pin_entry_controller_top_macros.svh
// ----------------------------------------------------------------------------
// keypad_pin_entry_controller_top_macros
// Assertion macros shared by the keypad PIN entry checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PIN_ENTRY_CONTROLLER_TOP_MACROS_SVH
`define KEYPAD_PIN_ENTRY_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define KPEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define KPEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked during reset
`define KPEC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kpec_pkg.sv
// ----------------------------------------------------------------------------
// kpec_pkg
// Key codes, event and display codes, and result word layout.
// ----------------------------------------------------------------------------
package kpec_pkg;

  localparam int DIGIT_W     = 4;
  localparam int DIGIT_SLOTS = 16;
  localparam int LEN_W       = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 144;

  typedef logic [DIGIT_W-1:0] key_code_t;

  localparam key_code_t KEY_A    = 4'd10;
  localparam key_code_t KEY_B    = 4'd11;
  localparam key_code_t KEY_C    = 4'd12;
  localparam key_code_t KEY_D    = 4'd13;
  localparam key_code_t KEY_STAR = 4'd14;
  localparam key_code_t KEY_HASH = 4'd15;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PIN     = 3'd1,
    EV_NEW_PIN = 3'd2,
    EV_FACE    = 3'd3,
    EV_CARD    = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    DISP_KEYPAD = 2'd0,
    DISP_UPDATE = 2'd1,
    DISP_FACE   = 2'd2,
    DISP_CARD   = 2'd3
  } display_mode_t;

  // first member is the MSB: matches out_tdata field order
  typedef struct packed {
    logic [DIGIT_SLOTS*DIGIT_W-1:0] display_digits;
    logic [LEN_W-1:0]               display_length;
    display_mode_t                  display_mode;
    logic                           display_valid;
    logic [DIGIT_SLOTS*DIGIT_W-1:0] event_digits;
    logic [LEN_W-1:0]               event_length;
    event_kind_t                    event_kind;
  } result_t;

  // rows 123A, 456B, 789C, *0#D
  function automatic key_code_t key_code(input logic [3:0] pos);
    key_code_t code;
    case (pos)
      4'd0:    code = 4'd1;
      4'd1:    code = 4'd2;
      4'd2:    code = 4'd3;
      4'd3:    code = KEY_A;
      4'd4:    code = 4'd4;
      4'd5:    code = 4'd5;
      4'd6:    code = 4'd6;
      4'd7:    code = KEY_B;
      4'd8:    code = 4'd7;
      4'd9:    code = 4'd8;
      4'd10:   code = 4'd9;
      4'd11:   code = KEY_C;
      4'd12:   code = KEY_STAR;
      4'd13:   code = 4'd0;
      4'd14:   code = KEY_HASH;
      default: code = KEY_D;
    endcase
    return code;
  endfunction

endpackage

>>> design/keypad_pin_entry_controller_top.sv
// ----------------------------------------------------------------------------
// keypad_pin_entry_controller_top
// PIN entry from a 4x4 keypad: digit buffer, submit, delete, clear,
// PIN update and face/card registration requests.
// ----------------------------------------------------------------------------
// Channel | Dir | Word
// in_     | in  | key position, door level, registration-mode update
// out_    | out | event (kind, length, digits) and display refresh
//
// One word per cycle while in_tready is high; each result is registered.
// Key decode, buffer update and packing sit between the input port and the
// output register; a skid register holds a second result under stall.
// in_tready is registered, is cleared by reset and otherwise drops only while the skid register is full.
// Synchronous active-low reset empties the buffer and clears all modes.
module keypad_pin_entry_controller_top #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] key_position, [4] door_open, [5] mode_update_valid,
  // [6] mode_update_value, [7] zero
  input  logic [kpec_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] event_kind, [7:3] event_length, [71:8] event_digits,
  // [72] display_valid, [74:73] display_mode, [79:75] display_length,
  // [143:80] display_digits
  output logic [kpec_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kpec_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [DIGIT_W-1:0] store_r [MAX_DIGITS];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               upd_r, upd_nxt;
  logic               regm_r, regm_nxt;
  logic               regk_r, regk_nxt;
  logic               store_we;

  result_t res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    accept, pop;

  key_code_t key;
  logic      door, regm_eff;

  assign accept = in_tvalid && in_tready;
  assign pop    = out_valid_r && out_tready;
  assign key    = key_code(in_tdata[3:0]);
  assign door   = in_tdata[4];
  assign regm_eff = in_tdata[5] ? in_tdata[6] : regm_r;

  always_comb begin
    count_nxt = count_r;
    upd_nxt   = upd_r;
    regm_nxt  = regm_eff;
    regk_nxt  = regk_r;
    store_we  = 1'b0;
    res       = '0;
    if (regm_eff) begin
      if (key == KEY_STAR) begin
        regm_nxt = 1'b0;
      end
    end else begin
      case (key)
        KEY_STAR: begin
          count_nxt = '0;
        end
        KEY_HASH: begin
          res.event_kind   = upd_r ? EV_NEW_PIN : EV_PIN;
          res.event_length = LEN_W'(count_r);
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (CNT_W'(i) < count_r) begin
              res.event_digits[DIGIT_W*i +: DIGIT_W] = store_r[i];
            end
          end
          upd_nxt   = 1'b0;
          count_nxt = '0;
        end
        KEY_A: begin
          if (door) begin
            upd_nxt   = 1'b1;
            count_nxt = '0;
          end
        end
        KEY_B: begin
          if (door) begin
            res.event_kind = EV_FACE;
            regm_nxt  = 1'b1;
            regk_nxt  = 1'b0;
            count_nxt = '0;
          end
        end
        KEY_C: begin
          if (door) begin
            res.event_kind = EV_CARD;
            regm_nxt  = 1'b1;
            regk_nxt  = 1'b1;
            count_nxt = '0;
          end
        end
        KEY_D: begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          if (count_r < CNT_W'(MAX_DIGITS)) begin
            store_we  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      endcase
      res.display_valid  = 1'b1;
      if (regm_nxt) begin
        res.display_mode = regk_nxt ? DISP_CARD : DISP_FACE;
      end else if (upd_nxt) begin
        res.display_mode = DISP_UPDATE;
      end else begin
        res.display_mode = DISP_KEYPAD;
      end
      res.display_length = LEN_W'(count_nxt);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (CNT_W'(i) < count_nxt) begin
          if (store_we && (CNT_W'(i) == count_r)) begin
            res.display_digits[DIGIT_W*i +: DIGIT_W] = key;
          end else begin
            res.display_digits[DIGIT_W*i +: DIGIT_W] = store_r[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      store_r[count_r[IDX_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      upd_r   <= 1'b0;
      regm_r  <= 1'b0;
      regk_r  <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      upd_r   <= upd_nxt;
      regm_r  <= regm_nxt;
      regk_r  <= regk_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      in_tready    <= 1'b0;
    end else begin
      in_tready <= 1'b1;
      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else begin
          in_tready <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || pop) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
          in_tready    <= 1'b0;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

>>> design/kpec_checker.sv
// ----------------------------------------------------------------------------
// kpec_checker
// Port-level checks for the keypad PIN entry controller.
// ----------------------------------------------------------------------------
`include "keypad_pin_entry_controller_top_macros.svh"

module kpec_checker #(
  parameter int MAX_DIGITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);

  `KPEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed under stall")

  `KPEC_ASSERT_IMPL(a_swallow_zero, clk, rst_n, out_tvalid && !out_tdata[72], out_tdata == 144'd0, "swallowed key gave nonzero word")

  `KPEC_ASSERT_IMPL(a_no_event_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != 3'd1 && out_tdata[2:0] != 3'd2, out_tdata[71:3] == 69'd0 && out_tdata[2:0] <= 3'd4, "bad event fields")

  `KPEC_ASSERT_IMPL(a_len_bound, clk, rst_n, out_tvalid, out_tdata[79:75] <= 5'(MAX_DIGITS) && out_tdata[7:3] <= 5'(MAX_DIGITS), "digit count over limit")

  `KPEC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid && !in_tready, "output valid or input ready after reset")

endmodule

bind keypad_pin_entry_controller_top kpec_checker #(.MAX_DIGITS(MAX_DIGITS)) u_kpec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
